// ----- hw/rtl/lmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants for the LRU tag array
// Geometry, address slicing, line states, per-way entry and beat layouts.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int SETS       = 1024;
    localparam int WAYS       = 4;
    localparam int SET_W      = $clog2(SETS);
    localparam int WAY_W      = $clog2(WAYS);
    localparam int TAG_W      = 12;
    localparam int TAG_SHIFT  = 20;
    localparam int SET_SHIFT  = 6;
    localparam int TIME_DELAY = 5;
    localparam int ADDR_W     = 32;
    localparam int NODE_W     = 6;
    localparam int TIME_W     = 32;

    typedef enum logic [1:0] {
        ST_MODIFIED  = 2'd0,
        ST_EXCLUSIVE = 2'd1,
        ST_SHARED    = 2'd2,
        ST_INVALID   = 2'd3
    } t_line_st;

    typedef enum logic [1:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_LOOKUP
    } t_ctl_st;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] age;
        t_line_st         st;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } t_upd;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [TIME_W-1:0] issue_time;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way_used;
        logic [NODE_W-1:0] message_source;
        logic [NODE_W-1:0] message_target;
        logic [TIME_W-1:0] message_time;
    } t_out;

    function automatic t_row reset_row();
        t_row row;
        for (int w = 0; w < WAYS; w++) begin
            row[w].tag = '0;
            row[w].age = WAY_W'(w);
            row[w].st  = ST_INVALID;
        end
        return row;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lmc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lmc_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_update: set update logic
// Tag compare, LRU victim pick, Shared marking and age rotation of one set.
// ----------------------------------------------------------------------------
module lmc_update (
    input  wire logic [lmc_pkg::TAG_W-1:0] i_tag,
    input  wire lmc_pkg::t_row             i_row,
    output lmc_pkg::t_row                  o_row,
    output lmc_pkg::t_upd                  o_upd
);
    import lmc_pkg::*;

    logic             match;
    logic [WAY_W-1:0] match_way;
    logic [WAY_W-1:0] victim_way;
    logic [WAY_W-1:0] chosen;
    logic [WAY_W-1:0] old_age;

    always_comb begin
        match      = 1'b0;
        match_way  = '0;
        victim_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w].tag == i_tag) begin
                match     = 1'b1;
                match_way = WAY_W'(w);
            end
            if (i_row[w].age == '0) begin
                victim_way = WAY_W'(w);
            end
        end
        chosen  = match ? match_way : victim_way;
        old_age = i_row[chosen].age;
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            o_row[w] = i_row[w];
            if (WAY_W'(w) == chosen) begin
                o_row[w].tag = i_tag;
                o_row[w].age = WAY_W'(WAYS - 1);
                o_row[w].st  = ST_SHARED;
            end else if (i_row[w].age > old_age) begin
                o_row[w].age = i_row[w].age - WAY_W'(1);
            end
        end
        o_upd.hit = match;
        o_upd.way = chosen;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lru_mesi_cache_tag_array.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_mesi_cache_tag_array: set-associative tag array with LRU ages
// Records a shared fill per beat and emits hit, way and outgoing message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one fill request
//   per beat. Output channel (o_out_valid / i_out_stall / o_out) returns one
//   result beat per request, in order.
//   Each request reads its set row from the tag RAM at accept, updates it in
//   the following cycle and writes it back while loading the output register.
//   The request and its set row are registered at accept; the result beat
//   is loaded into the output register and taken while i_out_stall is low.
//   The read-modify-write of the single-port-per-direction tag RAM keeps
//   requests from overlapping; the next request is taken only after the
//   previous write-back.
//   Reset: the controller sweeps the tag RAM, one set per cycle, writing
//   zero tags, Invalid states and ages equal to the way number to all
//   SETS (1024) sets; o_in_stall stays high during the sweep.
//   Output stall: a pending result holds in the output register; one more
//   request can be taken and its update waits in lookup, so further
//   requests are accepted only as the downstream side drains.
// ----------------------------------------------------------------------------
module lru_mesi_cache_tag_array (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lmc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lmc_pkg::t_out      o_out
);
    import lmc_pkg::*;

    t_ctl_st          r_st;
    t_ctl_st          n_st;
    logic [SET_W-1:0] r_clr_cnt;
    t_in              r_req;
    t_out             r_out;
    logic             r_out_vld;

    logic             out_free;
    logic             accept;
    logic             rd_en;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    t_row             wr_row;
    t_row             rd_row;
    t_row             upd_row;
    t_upd             upd;
    logic [ROW_W-1:0] rd_data;
    logic [WAYS-1:0]  zero_age;

    assign out_free = !r_out_vld || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign rd_row   = t_row'(rd_data);

    lmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (ROW_W'(wr_row)),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_in.address[SET_SHIFT +: SET_W]),
        .o_rd_data (rd_data)
    );

    lmc_update u_update (
        .i_tag (r_req.address[TAG_SHIFT +: TAG_W]),
        .i_row (rd_row),
        .o_row (upd_row),
        .o_upd (upd)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            CS_CLEAR: begin
                if (r_clr_cnt == SET_W'(SETS - 1)) begin
                    n_st = CS_IDLE;
                end
            end
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_st = CS_LOOKUP;
                end
            end
            CS_LOOKUP: begin
                if (out_free) begin
                    n_st = CS_IDLE;
                end
            end
            default: n_st = CS_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_clr_cnt;
        wr_row     = reset_row();
        case (r_st)
            CS_CLEAR: begin
                wr_en = 1'b1;
            end
            CS_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = i_in_valid;
            end
            CS_LOOKUP: begin
                wr_en   = out_free;
                wr_addr = r_req.address[SET_SHIFT +: SET_W];
                wr_row  = upd_row;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= CS_CLEAR;
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == CS_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + SET_W'(1);
            end
            if (r_st == CS_LOOKUP && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in;
        end
        if (r_st == CS_LOOKUP && out_free) begin
            r_out.hit            <= upd.hit;
            r_out.way_used       <= upd.way;
            r_out.message_source <= r_req.source_node;
            r_out.message_target <= r_req.target_node;
            r_out.message_time   <= r_req.issue_time + TIME_W'(TIME_DELAY);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            zero_age[w] = (upd_row[w].age == '0);
        end
    end

`ifndef ASSERT_OFF
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_st == CS_LOOKUP)
        else $error("accepted beat did not enter lookup");

    a_wb_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == CS_LOOKUP && wr_en) |=> o_out_valid)
        else $error("write-back without result beat");

    a_ages_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == CS_LOOKUP) |-> $onehot(zero_age))
        else $error("updated set lost its unique LRU way");

    a_hit_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == CS_LOOKUP && upd.hit) |->
            rd_row[upd.way].tag == r_req.address[TAG_SHIFT +: TAG_W])
        else $error("hit way tag mismatch");
`endif

endmodule
`default_nettype wire
